>>> design/safbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// safbu_pkg
// Shared codes, payload types and size helpers for the sized ALU / branch unit.
// ----------------------------------------------------------------------------
package safbu_pkg;

	typedef logic [63:0] data_t;
	typedef logic [3:0]  func_t;
	typedef logic [1:0]  size_t;
	typedef logic [1:0]  mode_t;
	typedef logic [1:0]  fault_t;

	// function codes
	localparam func_t FN_NOP  = 4'd0;
	localparam func_t FN_ADD  = 4'd1;
	localparam func_t FN_SUB  = 4'd2;
	localparam func_t FN_CMP  = 4'd3;
	localparam func_t FN_ASL  = 4'd4;
	localparam func_t FN_ASR  = 4'd5;
	localparam func_t FN_LSL  = 4'd6;
	localparam func_t FN_LSR  = 4'd7;
	localparam func_t FN_BEQ  = 4'd8;
	localparam func_t FN_BNE  = 4'd9;
	localparam func_t FN_CALL = 4'd10;
	localparam func_t FN_MOVE = 4'd11;

	// operand sizes
	localparam size_t SZ_BYTE  = 2'd0;
	localparam size_t SZ_WORD  = 2'd1;
	localparam size_t SZ_DWORD = 2'd2;
	localparam size_t SZ_LONG  = 2'd3;

	// destination modes
	localparam mode_t MD_REG = 2'd0;
	localparam mode_t MD_ABS = 2'd1;
	localparam mode_t MD_IND = 2'd2;
	localparam mode_t MD_IMM = 2'd3;

	// fault codes
	localparam fault_t FLT_NONE = 2'd0;
	localparam fault_t FLT_MODE = 2'd1;
	localparam fault_t FLT_INSN = 2'd2;

	typedef struct packed {
		func_t func;
		size_t op_size;
		data_t src_value;
		data_t dst_value;
		mode_t dst_mode;
		data_t pc_now;
	} req_t;

	typedef struct packed {
		data_t  result_value;
		logic   write_result;
		logic   pc_changed;
		data_t  next_pc;
		fault_t fault;
		logic   carry_out;
		logic   extend_out;
		logic   zero_out;
		logic   negative_out;
		logic   overflow_out;
	} rsp_t;

	function automatic data_t size_mask(input size_t sz);
		case (sz)
			SZ_BYTE:  size_mask = 64'h0000_0000_0000_00FF;
			SZ_WORD:  size_mask = 64'h0000_0000_0000_FFFF;
			SZ_DWORD: size_mask = 64'h0000_0000_FFFF_FFFF;
			default:  size_mask = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
	endfunction

	// sign bit of an operand of the given size
	function automatic logic size_msb(input data_t v, input size_t sz);
		case (sz)
			SZ_BYTE:  size_msb = v[7];
			SZ_WORD:  size_msb = v[15];
			SZ_DWORD: size_msb = v[31];
			default:  size_msb = v[63];
		endcase
	endfunction

	// carry out of a sized add/sub held in a 65-bit sum
	function automatic logic size_carry(input logic [64:0] v, input size_t sz);
		case (sz)
			SZ_BYTE:  size_carry = v[8];
			SZ_WORD:  size_carry = v[16];
			SZ_DWORD: size_carry = v[32];
			default:  size_carry = v[64];
		endcase
	endfunction

endpackage : safbu_pkg
`default_nettype wire

>>> design/safbu_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// safbu_req_if
// Request channel: one decoded instruction with its operands and pc.
// ----------------------------------------------------------------------------
interface safbu_req_if;
	import safbu_pkg::*;

	logic  valid;
	logic  ready;
	func_t func;
	size_t op_size;
	data_t src_value;
	data_t dst_value;
	mode_t dst_mode;
	data_t pc_now;

	modport source (
		output valid, func, op_size, src_value, dst_value, dst_mode, pc_now,
		input  ready
	);

	modport sink (
		input  valid, func, op_size, src_value, dst_value, dst_mode, pc_now,
		output ready
	);

endinterface : safbu_req_if
`default_nettype wire

>>> design/safbu_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// safbu_rsp_if
// Result channel: write-back value, pc update, fault code and flags.
// ----------------------------------------------------------------------------
interface safbu_rsp_if;
	import safbu_pkg::*;

	logic   valid;
	logic   ready;
	data_t  result_value;
	logic   write_result;
	logic   pc_changed;
	data_t  next_pc;
	fault_t fault;
	logic   carry_out;
	logic   extend_out;
	logic   zero_out;
	logic   negative_out;
	logic   overflow_out;

	modport source (
		output valid, result_value, write_result, pc_changed, next_pc, fault,
		       carry_out, extend_out, zero_out, negative_out, overflow_out,
		input  ready
	);

	modport sink (
		input  valid, result_value, write_result, pc_changed, next_pc, fault,
		       carry_out, extend_out, zero_out, negative_out, overflow_out,
		output ready
	);

endinterface : safbu_rsp_if
`default_nettype wire

>>> design/sized_alu_flags_branch_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sized_alu_flags_branch_unit_top
// Execute stage: sized ALU with condition flags, branch and call targets.
// ----------------------------------------------------------------------------
// One request per clock while the result channel does not stall. A request is
// captured in an input register, executed in a single pass (adder, barrel
// shifter, pc adder) and moves into the result register when that register is
// free or being read, so the sustained rate is one instruction per cycle. The
// flag register is updated as each instruction leaves the input register, so
// a BEQ/BNE directly behind a flag-setting instruction sees its flags with no
// bubble. A stalled result register holds only that one result; the input
// register keeps taking requests until it too is full.
// ----------------------------------------------------------------------------
module sized_alu_flags_branch_unit_top (
	input wire              clk,
	input wire              arst_n,
	safbu_req_if.sink       req,
	safbu_rsp_if.source     rsp
);
	import safbu_pkg::*;

	// input stage
	req_t  req_s1;
	logic  valid_s1;
	// result stage
	rsp_t  rsp_q;
	logic  rsp_valid_q;
	// flags
	logic  c_q, x_q, z_q, n_q, v_q;

	logic  advance;

	// datapath
	data_t       m, s, d, r, hm, res_mux, npc;
	logic [64:0] sum, diff;
	logic [6:0]  w, eff;
	logic [7:0]  cnt;
	logic        sign, asl_v;
	logic        c_d, x_d, z_d, n_d, v_d;
	logic        wr, pcc;
	fault_t      flt;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.func      <= req.func;
			req_s1.op_size   <= req.op_size;
			req_s1.src_value <= req.src_value;
			req_s1.dst_value <= req.dst_value;
			req_s1.dst_mode  <= req.dst_mode;
			req_s1.pc_now    <= req.pc_now;
		end
	end

	// operand prep
	assign m    = size_mask(req_s1.op_size);
	assign s    = req_s1.src_value & m;
	assign d    = req_s1.dst_value & m;
	assign w    = 7'd8 << req_s1.op_size;
	assign cnt  = req_s1.src_value[7:0];
	assign eff  = (cnt > {1'b0, w}) ? w : cnt[6:0];
	assign sum  = {1'b0, d} + {1'b0, s};
	assign diff = {1'b0, d} - {1'b0, s};
	assign sign = (req_s1.func == FN_ASR) && size_msb(d, req_s1.op_size);
	// top eff+1 bits of the sized operand, for the ASL overflow check
	assign hm   = m & ~(m >> (eff + 7'd1));
	assign asl_v = (eff >= w) ? (d != '0) : (((d & hm) != '0) && ((d & hm) != hm));

	always_comb begin
		flt = FLT_NONE;
		r   = d;
		wr  = 1'b0;
		pcc = 1'b0;
		npc = req_s1.pc_now;
		c_d = c_q;
		x_d = x_q;
		z_d = z_q;
		n_d = n_q;
		v_d = v_q;

		if (req_s1.func > FN_MOVE) begin
			flt = FLT_INSN;
		end else if ((req_s1.func inside {FN_ADD, FN_SUB, FN_CMP, FN_MOVE}) &&
		             req_s1.dst_mode == MD_IMM) begin
			flt = FLT_MODE;
		end else if ((req_s1.func inside {FN_ASL, FN_ASR, FN_LSL, FN_LSR}) &&
		             req_s1.dst_mode != MD_REG) begin
			flt = FLT_MODE;
		end else if ((req_s1.func inside {FN_BEQ, FN_BNE}) &&
		             req_s1.dst_mode != MD_IMM) begin
			flt = FLT_MODE;
		end else begin
			case (req_s1.func)
				FN_ADD: begin
					r   = sum[63:0] & m;
					c_d = size_carry(sum, req_s1.op_size);
					x_d = c_d;
					v_d = size_msb((s ^ r) & (d ^ r), req_s1.op_size);
					wr  = 1'b1;
				end
				FN_SUB, FN_CMP: begin
					r   = diff[63:0] & m;
					c_d = diff[64];
					if (req_s1.func == FN_SUB) begin
						x_d = c_d;
						wr  = 1'b1;
					end
					v_d = size_msb((s ^ d) & (r ^ d), req_s1.op_size);
				end
				FN_ASL, FN_LSL: begin
					r   = (d << eff) & m;
					v_d = 1'b0;
					if (cnt == 8'd0) begin
						c_d = 1'b0;
					end else begin
						c_d = d[6'(w - eff)];
						x_d = c_d;
						if (req_s1.func == FN_ASL)
							v_d = asl_v;
					end
					wr = 1'b1;
				end
				FN_ASR, FN_LSR: begin
					r   = (d >> eff) | (sign ? (m & ~(m >> eff)) : '0);
					v_d = 1'b0;
					if (cnt == 8'd0) begin
						c_d = 1'b0;
					end else begin
						c_d = d[6'(eff - 7'd1)];
						x_d = c_d;
					end
					wr = 1'b1;
				end
				FN_BEQ, FN_BNE: begin
					if ((req_s1.func == FN_BEQ) == z_q) begin
						pcc = 1'b1;
						if (req_s1.op_size == SZ_LONG)
							npc = req_s1.src_value;
						else
							npc = req_s1.pc_now +
							      (s | (size_msb(s, req_s1.op_size) ? ~m : '0));
					end
				end
				FN_CALL: begin
					pcc = 1'b1;
					npc = (req_s1.op_size == SZ_LONG) ? req_s1.src_value
					                                  : req_s1.pc_now + s;
				end
				FN_MOVE: begin
					r   = s;
					c_d = 1'b0;
					v_d = 1'b0;
					wr  = 1'b1;
				end
				default: begin
				end
			endcase
			// every sized op but NOP, branches and CALL sets N and Z
			if (req_s1.func inside {[FN_ADD:FN_LSR], FN_MOVE}) begin
				z_d = (r == '0);
				n_d = size_msb(r, req_s1.op_size);
			end
		end
	end

	assign res_mux = wr ? ((req_s1.dst_value & ~m) | (r & m)) : req_s1.dst_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			c_q         <= 1'b0;
			x_q         <= 1'b0;
			z_q         <= 1'b0;
			n_q         <= 1'b0;
			v_q         <= 1'b0;
		end else begin
			if (advance) begin
				rsp_valid_q <= 1'b1;
				c_q         <= c_d;
				x_q         <= x_d;
				z_q         <= z_d;
				n_q         <= n_d;
				v_q         <= v_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.result_value <= res_mux;
			rsp_q.write_result <= wr;
			rsp_q.pc_changed   <= pcc;
			rsp_q.next_pc      <= npc;
			rsp_q.fault        <= flt;
			rsp_q.carry_out    <= c_d;
			rsp_q.extend_out   <= x_d;
			rsp_q.zero_out     <= z_d;
			rsp_q.negative_out <= n_d;
			rsp_q.overflow_out <= v_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = rsp_q.result_value;
	assign rsp.write_result = rsp_q.write_result;
	assign rsp.pc_changed   = rsp_q.pc_changed;
	assign rsp.next_pc      = rsp_q.next_pc;
	assign rsp.fault        = rsp_q.fault;
	assign rsp.carry_out    = rsp_q.carry_out;
	assign rsp.extend_out   = rsp_q.extend_out;
	assign rsp.zero_out     = rsp_q.zero_out;
	assign rsp.negative_out = rsp_q.negative_out;
	assign rsp.overflow_out = rsp_q.overflow_out;

endmodule : sized_alu_flags_branch_unit_top
`default_nettype wire

>>> bench/tb_sized_alu_flags_branch_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sized_alu_flags_branch_unit_top
// Self-checking bench for the sized ALU / branch unit. A behavioural model of
// the execute stage, with its own condition flags, predicts every result in
// request order. Results are checked field by field as they retire. Both
// channels idle and stall at random, including one long result stall and a
// sender pause until everything has retired.
// ----------------------------------------------------------------------------
module tb_sized_alu_flags_branch_unit_top;
	import safbu_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned SETTLE      = 8;
	localparam func_t       FN_ILL_LO   = FN_MOVE + 4'd1;
	localparam func_t       FN_ILL_HI   = 4'hF;

	logic clk = 1'b0;
	logic arst_n;

	safbu_req_if req_if ();
	safbu_rsp_if rsp_if ();

	sized_alu_flags_branch_unit_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted condition codes
	logic ccr_c = 1'b0, ccr_x = 1'b0, ccr_z = 1'b0, ccr_n = 1'b0, ccr_v = 1'b0;

	rsp_t        retire_q[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          src_idle = 1'b1;
	bit          sink_idle = 1'b1;
	bit          sink_hold_req = 1'b0;

	// Executes one instruction against the predicted flags.
	function automatic rsp_t execute_insn(input req_t q);
		rsp_t        o;
		data_t       m, s, d, r, off, top, ones;
		int unsigned w, n, eff;
		logic        sign, upd_nz;
		w   = 8 << q.op_size;
		m   = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		s   = q.src_value & m;
		d   = q.dst_value & m;
		r   = d;
		n   = 32'(q.src_value[7:0]);
		eff = (n > w) ? w : n;
		upd_nz = 1'b0;
		o.result_value = q.dst_value;
		o.write_result = 1'b0;
		o.pc_changed   = 1'b0;
		o.next_pc      = q.pc_now;
		o.fault        = FLT_NONE;
		if (q.func > FN_MOVE) begin
			o.fault = FLT_INSN;
		end else if ((q.func inside {FN_ADD, FN_SUB, FN_CMP, FN_MOVE}) && q.dst_mode == MD_IMM) begin
			o.fault = FLT_MODE;
		end else if ((q.func inside {[FN_ASL:FN_LSR]}) && q.dst_mode != MD_REG) begin
			o.fault = FLT_MODE;
		end else if ((q.func inside {FN_BEQ, FN_BNE}) && q.dst_mode != MD_IMM) begin
			o.fault = FLT_MODE;
		end else begin
			case (q.func)
				FN_ADD: begin
					r     = (s + d) & m;
					ccr_c = (s > (m - d));
					ccr_x = ccr_c;
					ccr_v = 1'(((s ^ r) & (d ^ r)) >> (w - 1));
					upd_nz = 1'b1;
					o.write_result = 1'b1;
				end
				FN_SUB, FN_CMP: begin
					r     = (d - s) & m;
					ccr_c = (s > d);
					// compare leaves extend alone
					if (q.func == FN_SUB) begin
						ccr_x = ccr_c;
						o.write_result = 1'b1;
					end
					ccr_v = 1'(((s ^ d) & (r ^ d)) >> (w - 1));
					upd_nz = 1'b1;
				end
				FN_ASL, FN_LSL: begin
					if (eff == 0) r = d;
					else if (eff >= w) r = '0;
					else r = (d << eff) & m;
					ccr_v = 1'b0;
					if (n == 0) begin
						ccr_c = 1'b0;
					end else begin
						ccr_c = d[w - eff];
						ccr_x = ccr_c;
						// V when any bit passing through the sign differs
						if (q.func == FN_ASL) begin
							if (eff >= w) begin
								ccr_v = (d != '0);
							end else begin
								top   = d >> (w - 1 - eff);
								ones  = (eff + 1 >= 64) ? '1 : ((64'd1 << (eff + 1)) - 64'd1);
								ccr_v = (top != '0) && (top != ones);
							end
						end
					end
					upd_nz = 1'b1;
					o.write_result = 1'b1;
				end
				FN_ASR, FN_LSR: begin
					sign = (q.func == FN_ASR) ? d[w - 1] : 1'b0;
					if (eff == 0) r = d;
					else if (eff >= w) r = sign ? m : '0;
					else r = (d >> eff) | (sign ? (m & ~(m >> eff)) : '0);
					if (n == 0) begin
						ccr_c = 1'b0;
					end else begin
						ccr_c = d[eff - 1];
						ccr_x = ccr_c;
					end
					ccr_v = 1'b0;
					upd_nz = 1'b1;
					o.write_result = 1'b1;
				end
				FN_BEQ, FN_BNE: begin
					if ((q.func == FN_BEQ) == ccr_z) begin
						o.pc_changed = 1'b1;
						if (q.op_size == SZ_LONG) begin
							o.next_pc = q.src_value;
						end else begin
							off = s;
							if (s[w - 1]) off = off | ~m;
							o.next_pc = q.pc_now + off;
						end
					end
				end
				FN_CALL: begin
					o.pc_changed = 1'b1;
					o.next_pc = (q.op_size == SZ_LONG) ? q.src_value : q.pc_now + s;
				end
				FN_MOVE: begin
					r     = s;
					ccr_c = 1'b0;
					ccr_v = 1'b0;
					upd_nz = 1'b1;
					o.write_result = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (upd_nz) begin
			ccr_z = (r == '0);
			ccr_n = r[w - 1];
		end
		if (o.write_result) o.result_value = (q.dst_value & ~m) | (r & m);
		o.carry_out    = ccr_c;
		o.extend_out   = ccr_x;
		o.zero_out     = ccr_z;
		o.negative_out = ccr_n;
		o.overflow_out = ccr_v;
		return o;
	endfunction

	function automatic data_t rand_operand();
		data_t v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = 64'd1 << $urandom_range(0, 63);
			// just either side of a sign boundary
			3: v = (64'd1 << ((8 << $urandom_range(0, 3)) - 1)) - $urandom_range(0, 1);
			4: v = {$urandom, $urandom} & 64'hFF;
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic req_t rand_insn();
		req_t q;
		if ($urandom_range(0, 19) == 0) q.func = func_t'($urandom_range(FN_ILL_LO, FN_ILL_HI));
		else q.func = func_t'($urandom_range(FN_NOP, FN_MOVE));
		q.op_size   = size_t'($urandom_range(0, 3));
		q.src_value = rand_operand();
		q.dst_value = rand_operand();
		q.pc_now    = {$urandom, $urandom};
		if ((q.func inside {[FN_ASL:FN_LSR]}) && $urandom_range(0, 3) != 0)
			q.src_value[7:0] = 8'($urandom_range(0, (8 << q.op_size) + 2));
		q.dst_mode = mode_t'($urandom_range(0, 3));
		if ($urandom_range(0, 9) != 0) begin
			case (q.func)
				FN_ADD, FN_SUB, FN_CMP, FN_MOVE: q.dst_mode = mode_t'($urandom_range(MD_REG, MD_IND));
				FN_ASL, FN_ASR, FN_LSL, FN_LSR:  q.dst_mode = MD_REG;
				FN_BEQ, FN_BNE:                  q.dst_mode = MD_IMM;
				default: begin
				end
			endcase
		end
		return q;
	endfunction

	task automatic send_insn(input req_t q);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 14) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.func      <= q.func;
		req_if.op_size   <= q.op_size;
		req_if.src_value <= q.src_value;
		req_if.dst_value <= q.dst_value;
		req_if.dst_mode  <= q.dst_mode;
		req_if.pc_now    <= q.pc_now;
		do @(posedge clk); while (!req_if.ready);
		retire_q.push_back(execute_insn(q));
	endtask

	// withdraw the last request before waiting, so it is not taken twice
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (retire_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		send_insn('{FN_NOP,  SZ_BYTE,  64'h0, 64'h1234, MD_REG, 64'h100});
		// byte add carries out, upper bits of the destination kept
		send_insn('{FN_ADD,  SZ_BYTE,  64'hFF, 64'hDEAD_BEEF_CAFE_BA01, MD_REG, 64'h0});
		send_insn('{FN_ADD,  SZ_WORD,  64'h1, 64'h7FFF, MD_ABS, 64'h0});
		send_insn('{FN_ADD,  SZ_LONG,  '1, '1, MD_IND, '1});
		send_insn('{FN_SUB,  SZ_DWORD, 64'h1, 64'hFFFF_FFFF_0000_0000, MD_REG, 64'h0});
		send_insn('{FN_CMP,  SZ_BYTE,  64'h01, 64'h80, MD_REG, 64'h0});
		send_insn('{FN_MOVE, SZ_LONG,  64'h8000_0000_0000_0000, 64'h5, MD_ABS, 64'h0});
		// zero count: carry cleared, extend kept
		send_insn('{FN_ASL,  SZ_BYTE,  64'hFF00, 64'h81, MD_REG, 64'h0});
		send_insn('{FN_ASL,  SZ_BYTE,  64'h1, 64'h40, MD_REG, 64'h0});
		send_insn('{FN_ASL,  SZ_WORD,  64'hC8, 64'h0001, MD_REG, 64'h0});
		send_insn('{FN_ASR,  SZ_BYTE,  64'h3, 64'h90, MD_REG, 64'h0});
		send_insn('{FN_ASR,  SZ_LONG,  64'hFF, 64'h8000_0000_0000_0001, MD_REG, 64'h0});
		send_insn('{FN_LSL,  SZ_DWORD, 64'h20, 64'h1, MD_REG, 64'h0});
		send_insn('{FN_LSR,  SZ_LONG,  64'h40, 64'h8000_0000_0000_0000, MD_REG, 64'h0});
		send_insn('{FN_LSR,  SZ_WORD,  64'h0, 64'h0, MD_REG, 64'h0});
		// equal operands set Z, then a taken branch with a negative offset
		send_insn('{FN_SUB,  SZ_BYTE,  64'h55, 64'h55, MD_REG, 64'h0});
		send_insn('{FN_BEQ,  SZ_BYTE,  64'hF0, 64'h0, MD_IMM, 64'h1000});
		send_insn('{FN_BNE,  SZ_WORD,  64'h10, 64'h0, MD_IMM, 64'h1000});
		send_insn('{FN_CMP,  SZ_WORD,  64'h1, 64'h2, MD_IND, 64'h0});
		send_insn('{FN_BNE,  SZ_DWORD, 64'h8000_0000, 64'h0, MD_IMM, 64'h1_0000_0000});
		send_insn('{FN_BEQ,  SZ_LONG,  64'h4000, 64'h0, MD_IMM, 64'h2000});
		send_insn('{FN_CALL, SZ_BYTE,  64'hFF, 64'h0, MD_REG, '1});
		send_insn('{FN_CALL, SZ_LONG,  64'hABCD_0000_1234_5678, 64'h0, MD_ABS, 64'h8});
		// address mode faults, then an illegal function code
		send_insn('{FN_ADD,  SZ_WORD,  64'h1, 64'h1, MD_IMM, 64'h0});
		send_insn('{FN_LSL,  SZ_BYTE,  64'h1, 64'h1, MD_IND, 64'h0});
		send_insn('{FN_BEQ,  SZ_BYTE,  64'h4, 64'h0, MD_REG, 64'h40});
		send_insn('{FN_ILL_HI, SZ_LONG, '1, '1, MD_REG, '1});
	endtask

	// idling pattern changes every hundred requests, some stretches with none
	task automatic test_random_mix(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				src_idle  = $urandom_range(0, 1);
				sink_idle = $urandom_range(0, 1);
			end
			send_insn(rand_insn());
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_branch_after_flags(input int unsigned pairs);
		req_t setup, br;
		repeat (pairs) begin
			setup = rand_insn();
			setup.func = $urandom_range(0, 1) ? FN_CMP : FN_SUB;
			setup.dst_mode = MD_REG;
			if ($urandom_range(0, 1)) setup.src_value = setup.dst_value;
			send_insn(setup);
			br = rand_insn();
			br.func = $urandom_range(0, 1) ? FN_BEQ : FN_BNE;
			br.dst_mode = MD_IMM;
			send_insn(br);
		end
	endtask

	// long result stall with the sender flat out: both registers fill
	task automatic test_result_backpressure();
		src_idle = 1'b0;
		sink_hold_req = 1'b1;
		repeat (40) send_insn(rand_insn());
		src_idle = 1'b1;
	endtask

	task automatic test_pause_until_drained();
		repeat (5) begin
			repeat (20) send_insn(rand_insn());
			wait_drained();
		end
	endtask

	initial begin : result_sink
		int unsigned hold;
		rsp_if.ready <= 1'b0;
		forever begin
			hold = sink_idle ? $urandom_range(0, 14) : 0;
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			@(negedge clk);
			if (hold != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
		end
	end

	task automatic cmp_field(input string name, input data_t want, input data_t got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (retire_q.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request outstanding, expected none, actual %h",
					$time, rsp_if.result_value);
			end else begin
				want = retire_q.pop_front();
				cmp_field("result_value", want.result_value, rsp_if.result_value);
				cmp_field("write_result", want.write_result, rsp_if.write_result);
				cmp_field("pc_changed", want.pc_changed, rsp_if.pc_changed);
				cmp_field("next_pc", want.next_pc, rsp_if.next_pc);
				cmp_field("fault", want.fault, rsp_if.fault);
				cmp_field("carry_out", want.carry_out, rsp_if.carry_out);
				cmp_field("extend_out", want.extend_out, rsp_if.extend_out);
				cmp_field("zero_out", want.zero_out, rsp_if.zero_out);
				cmp_field("negative_out", want.negative_out, rsp_if.negative_out);
				cmp_field("overflow_out", want.overflow_out, rsp_if.overflow_out);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.func      <= FN_NOP;
		req_if.op_size   <= SZ_BYTE;
		req_if.src_value <= '0;
		req_if.dst_value <= '0;
		req_if.dst_mode  <= MD_REG;
		req_if.pc_now    <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(1230);
		test_branch_after_flags(80);
		test_result_backpressure();
		test_pause_until_drained();

		@(negedge clk);
		req_if.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && retire_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule : tb_sized_alu_flags_branch_unit_top
